// ===== hdl/paged_record_packer_with_count_header_assert.svh =====
// Assertion macros for the paged record packer.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef PAGED_RECORD_PACKER_WITH_COUNT_HEADER_ASSERT_SVH
`define PAGED_RECORD_PACKER_WITH_COUNT_HEADER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PRPC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PRPC_ASSERT(lbl, prop, msg)
`define PRPC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hdl/prpc_pkg.sv =====
// Shared types, widths and codes for the paged record packer.
// No dependencies.
package prpc_pkg;

  localparam int DEF_PAGE_BYTES       = 4096;
  localparam int DEF_MAX_PAGES        = 64;
  localparam int DEF_MAX_RECORD_BYTES = 256;

  localparam int HEADER_BYTES = 4;
  localparam int WORD_BYTES   = 4;

  localparam int KIND_W      = 2;
  localparam int PAGE_NUM_W  = 6;
  localparam int BYTE_OFF_W  = 12;
  localparam int DATA_W      = 32;
  localparam int RB_W        = 9;
  localparam int PAGES_CFG_W = 7;
  localparam int PB_W        = 9;
  localparam int POINTS_W    = 11;
  localparam int OFFSET_W    = 13;
  localparam int USED_W      = 19;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam int FIFO_DEPTH = 4;  // power of two, pointers wrap naturally

  localparam logic OPC_CLOSE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_BYTES  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PUSH2,
    FS_DIV
  } front_state_t;

  typedef struct packed {
    kind_t                  kind;
    logic [PAGE_NUM_W-1:0]  page_number;
    logic [BYTE_OFF_W-1:0]  byte_offset;
    logic [DATA_W-1:0]      write_data;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [RB_W-1:0] dividend;
    logic [PB_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic [RB_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/paged_record_packer_with_count_header.sv =====
// Paged record packer: front end, divider, result queue, output stage.
// The first result of an item goes through the result queue and the output register before it can be taken.
// Non-first words, closes and rejects are handled in the idle state; a header with a reject
// pushes the reject from the second-push state; a placed first word waits in the divide state
// for the 9-step point-count divider (a page header write overlaps it); a full result queue stalls input.
// Reset (synchronous, rst_n low): page 0, offset 4, count 0, pages 1, point 4.
module paged_record_packer_with_count_header #(
  parameter int PAGE_BYTES       = prpc_pkg::DEF_PAGE_BYTES,
  parameter int MAX_PAGES        = prpc_pkg::DEF_MAX_PAGES,
  parameter int MAX_RECORD_BYTES = prpc_pkg::DEF_MAX_RECORD_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic                              in_first_word,
  input  logic [prpc_pkg::RB_W-1:0]         in_record_bytes,
  input  logic [prpc_pkg::DATA_W-1:0]       in_data_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [prpc_pkg::KIND_W-1:0]       out_kind,
  output logic [prpc_pkg::PAGE_NUM_W-1:0]   out_page_number,
  output logic [prpc_pkg::BYTE_OFF_W-1:0]   out_byte_offset,
  output logic [prpc_pkg::DATA_W-1:0]       out_write_data,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [prpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import prpc_pkg::*;

  logic     fifo_push;
  logic     fifo_full;
  logic     fifo_pop;
  logic     fifo_empty;
  result_t  fifo_wr;
  result_t  fifo_rd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  prpc_front #(
    .PAGE_BYTES       (PAGE_BYTES),
    .MAX_PAGES        (MAX_PAGES),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_first_word   (in_first_word),
    .in_record_bytes (in_record_bytes),
    .in_data_word    (in_data_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fifo_push       (fifo_push),
    .fifo_entry      (fifo_wr),
    .fifo_full       (fifo_full),
    .div_req         (div_req),
    .div_rsp         (div_rsp)
  );

  prpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  prpc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fifo_push),
    .wr_data (fifo_wr),
    .full    (fifo_full),
    .pop     (fifo_pop),
    .empty   (fifo_empty),
    .rd_data (fifo_rd)
  );

  prpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (fifo_empty),
    .q_data          (fifo_rd),
    .q_pop           (fifo_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_page_number (out_page_number),
    .out_byte_offset (out_byte_offset),
    .out_write_data  (out_write_data),
    .out_last        (out_last)
  );

endmodule

// ===== hdl/prpc_div.sv =====
// Restoring divider, one quotient bit per cycle: record bytes over point size.
// Depends on prpc_pkg.
module prpc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  prpc_pkg::div_req_t req,
  output prpc_pkg::div_rsp_t rsp
);
  import prpc_pkg::*;

  localparam int CNT_W = $clog2(RB_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RB_W-1:0]  dq_r, dq_nxt;
  logic [PB_W-1:0]  rem_r, rem_nxt;
  logic [PB_W-1:0]  dvs_r, dvs_nxt;
  logic [PB_W:0]    rem_sh;
  logic [PB_W:0]    rem_dif;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, dq_r[RB_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_dif = rem_sh - {1'b0, dvs_r};
    cnt_nxt = cnt_r;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (req.start) begin
      cnt_nxt = CNT_W'(RB_W);
      dq_nxt  = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      rem_nxt = ge ? rem_dif[PB_W-1:0] : rem_sh[PB_W-1:0];
      dq_nxt  = {dq_r[RB_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = cnt_r != '0;
  assign rsp.quotient = dq_r;

endmodule

// ===== hdl/prpc_front.sv =====
// Front end: takes items, checks capacity and page fit, keeps packing state
// and config, and queues the result items. Depends on prpc_pkg.
module prpc_front #(
  parameter int PAGE_BYTES       = prpc_pkg::DEF_PAGE_BYTES,
  parameter int MAX_PAGES        = prpc_pkg::DEF_MAX_PAGES,
  parameter int MAX_RECORD_BYTES = prpc_pkg::DEF_MAX_RECORD_BYTES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic                               in_first_word,
  input  logic [prpc_pkg::RB_W-1:0]          in_record_bytes,
  input  logic [prpc_pkg::DATA_W-1:0]        in_data_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [prpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               fifo_push,
  output prpc_pkg::result_t                  fifo_entry,
  input  logic                               fifo_full,
  output prpc_pkg::div_req_t                 div_req,
  input  prpc_pkg::div_rsp_t                 div_rsp
);
  import prpc_pkg::*;

  front_state_t            state_r, state_nxt;
  logic [PAGE_NUM_W-1:0]   page_r, page_nxt;
  logic [OFFSET_W-1:0]     offset_r, offset_nxt;
  logic [POINTS_W-1:0]     points_r, points_nxt;
  logic [USED_W-1:0]       used_r, used_nxt;
  logic [RB_W-1:0]         rwo_r, rwo_nxt;
  logic                    drop_r, drop_nxt;
  logic                    pend_r, pend_nxt;
  result_t                 second_r, second_nxt;
  logic [PAGES_CFG_W-1:0]  pages_cfg_r;
  logic [PB_W-1:0]         pb_cfg_r;

  logic                    acc;
  logic [PAGES_CFG_W-1:0]  pages_clamp;
  logic [PAGES_CFG_W-1:0]  page_inc;
  logic [PAGE_NUM_W-1:0]   new_page;
  logic                    last_page;
  logic [USED_W-1:0]       cap;
  logic [USED_W:0]         used_sum;
  logic                    bad;
  logic [OFFSET_W:0]       off_sum;
  logic                    need_new;
  logic [OFFSET_W-1:0]     base_off;
  logic [USED_W-1:0]       base_used;
  logic [PAGE_NUM_W-1:0]   base_page;
  logic [PB_W-1:0]         pb_eff;
  logic [OFFSET_W-1:0]     word_off;
  result_t                 hdr_res, rej_res, first_res, word_res;

  function automatic result_t mk_res(kind_t k, logic [PAGE_NUM_W-1:0] pg,
                                     logic [BYTE_OFF_W-1:0] off,
                                     logic [DATA_W-1:0] d, logic lst);
    result_t r;
    r.kind        = k;
    r.page_number = pg;
    r.byte_offset = off;
    r.write_data  = d;
    r.last        = lst;
    return r;
  endfunction

  assign acc       = in_valid && in_ready;
  assign in_ready  = (state_r == FS_IDLE) && !fifo_full;
  assign cfg_ready = 1'b1;

  always_comb begin
    pages_clamp = (pages_cfg_r > PAGES_CFG_W'(MAX_PAGES)) ? PAGES_CFG_W'(MAX_PAGES)
                                                           : pages_cfg_r;
    page_inc  = {1'b0, page_r} + PAGES_CFG_W'(1);
    new_page  = page_inc[PAGE_NUM_W-1:0];
    last_page = page_inc >= pages_clamp;
    cap       = USED_W'(pages_clamp) * USED_W'(PAGE_BYTES);
    used_sum  = {1'b0, used_r} + (USED_W+1)'(in_record_bytes);
    bad = (in_record_bytes == '0) || (in_record_bytes[1:0] != 2'b00)
       || (in_record_bytes > RB_W'(MAX_RECORD_BYTES))
       || ({1'b0, used_r} >= (USED_W+1)'(cap)) || (used_sum >= (USED_W+1)'(cap));
    off_sum   = {1'b0, offset_r} + (OFFSET_W+1)'(in_record_bytes);
    need_new  = off_sum > (OFFSET_W+1)'(PAGE_BYTES);
    base_off  = need_new ? OFFSET_W'(HEADER_BYTES) : offset_r;
    base_used = need_new ? USED_W'(USED_W'(PAGE_BYTES) * USED_W'(new_page)
                                   + USED_W'(HEADER_BYTES))
                         : used_r;
    base_page = need_new ? new_page : page_r;
    pb_eff    = (pb_cfg_r < PB_W'(WORD_BYTES)) ? PB_W'(WORD_BYTES) : pb_cfg_r;
    word_off  = offset_r - OFFSET_W'(rwo_r);

    hdr_res   = mk_res(KIND_HEADER, page_r, '0, DATA_W'(points_r), 1'b0);
    rej_res   = mk_res(KIND_REJECT, page_r, '0, '0, 1'b1);
    first_res = mk_res(KIND_DATA, base_page, base_off[BYTE_OFF_W-1:0], in_data_word, 1'b1);
    word_res  = mk_res(KIND_DATA, page_r, word_off[BYTE_OFF_W-1:0], in_data_word, 1'b1);
  end

  always_comb begin
    state_nxt  = state_r;
    page_nxt   = page_r;
    offset_nxt = offset_r;
    points_nxt = points_r;
    used_nxt   = used_r;
    rwo_nxt    = rwo_r;
    drop_nxt   = drop_r;
    pend_nxt   = pend_r;
    second_nxt = second_r;
    fifo_push  = 1'b0;
    fifo_entry = hdr_res;
    div_req.start    = 1'b0;
    div_req.dividend = in_record_bytes;
    div_req.divisor  = pb_eff;
    case (state_r)
      FS_IDLE: begin
        if (acc) begin
          if (in_opcode == OPC_CLOSE) begin
            fifo_push       = 1'b1;
            fifo_entry      = hdr_res;
            fifo_entry.last = 1'b1;
          end else if (in_first_word) begin
            rwo_nxt = '0;
            if (bad) begin
              fifo_push  = 1'b1;
              fifo_entry = rej_res;
              drop_nxt   = 1'b1;
            end else if (need_new && last_page) begin
              fifo_push  = 1'b1;
              fifo_entry = hdr_res;
              second_nxt = rej_res;
              drop_nxt   = 1'b1;
              state_nxt  = FS_PUSH2;
            end else begin
              drop_nxt      = 1'b0;
              page_nxt      = base_page;
              offset_nxt    = base_off + OFFSET_W'(in_record_bytes);
              used_nxt      = base_used + USED_W'(in_record_bytes);
              points_nxt    = need_new ? '0 : points_r;
              rwo_nxt       = in_record_bytes - RB_W'(WORD_BYTES);
              div_req.start = 1'b1;
              pend_nxt      = 1'b1;
              fifo_push     = 1'b1;
              if (need_new) begin
                fifo_entry = hdr_res;
                second_nxt = first_res;
                state_nxt  = FS_PUSH2;
              end else begin
                fifo_entry = first_res;
                state_nxt  = FS_DIV;
              end
            end
          end else if (!drop_r && (rwo_r != '0)) begin
            fifo_push  = 1'b1;
            fifo_entry = word_res;
            rwo_nxt    = rwo_r - RB_W'(WORD_BYTES);
          end
        end
      end
      FS_PUSH2: begin
        if (!fifo_full) begin
          fifo_push  = 1'b1;
          fifo_entry = second_r;
          state_nxt  = pend_r ? FS_DIV : FS_IDLE;
        end
      end
      FS_DIV: begin
        if (!div_rsp.busy) begin
          points_nxt = points_r + POINTS_W'(div_rsp.quotient);
          pend_nxt   = 1'b0;
          state_nxt  = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_IDLE;
      page_r      <= '0;
      offset_r    <= OFFSET_W'(HEADER_BYTES);
      points_r    <= '0;
      used_r      <= USED_W'(HEADER_BYTES);
      rwo_r       <= '0;
      drop_r      <= 1'b0;
      pend_r      <= 1'b0;
      pages_cfg_r <= PAGES_CFG_W'(1);
      pb_cfg_r    <= PB_W'(WORD_BYTES);
    end else begin
      state_r  <= state_nxt;
      page_r   <= page_nxt;
      offset_r <= offset_nxt;
      points_r <= points_nxt;
      used_r   <= used_nxt;
      rwo_r    <= rwo_nxt;
      drop_r   <= drop_nxt;
      pend_r   <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAGES_IN_USE: pages_cfg_r <= cfg_data[PAGES_CFG_W-1:0];
          CFG_POINT_BYTES:  pb_cfg_r    <= cfg_data[PB_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    second_r <= second_nxt;
  end

endmodule

// ===== hdl/prpc_fifo.sv =====
// Short result queue between front and back ends.
// Depends on prpc_pkg and the assertion header.
`include "paged_record_packer_with_count_header_assert.svh"
module prpc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  prpc_pkg::result_t wr_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output prpc_pkg::result_t rd_data
);
  import prpc_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t          mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == CNT_W'(FIFO_DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `PRPC_ASSERT(a_no_overflow, push |-> !full, "result pushed into full queue")
  `PRPC_ASSERT(a_no_underflow, pop |-> !empty, "result popped from empty queue")
  `PRPC_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + CNT_W'(1), "queue count lost a push")

endmodule

// ===== hdl/prpc_back.sv =====
// Back end: output register stage that drains the result queue.
// Depends on prpc_pkg.
module prpc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  prpc_pkg::result_t                 q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [prpc_pkg::KIND_W-1:0]       out_kind,
  output logic [prpc_pkg::PAGE_NUM_W-1:0]   out_page_number,
  output logic [prpc_pkg::BYTE_OFF_W-1:0]   out_byte_offset,
  output logic [prpc_pkg::DATA_W-1:0]       out_write_data,
  output logic                              out_last
);
  import prpc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    q_pop     = !q_empty && (!valid_r || out_ready);
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_data;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = res_r.kind;
  assign out_page_number = res_r.page_number;
  assign out_byte_offset = res_r.byte_offset;
  assign out_write_data  = res_r.write_data;
  assign out_last        = res_r.last;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the paged record packer (paged_record_packer_with_count_header).
// Drives record words and closes through valid/ready, predicts every page write, header and
// reject in a local model and checks results in order. Depends on prpc_pkg and the RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prpc_pkg::*;

  localparam int PAGE_B     = DEF_PAGE_BYTES;
  localparam int MAXP       = DEF_MAX_PAGES;
  localparam int MAXR       = DEF_MAX_RECORD_BYTES;
  localparam int CYCLE_CAP  = 400000;
  localparam int SETTLE     = 24;
  localparam logic OPC_PUT  = 1'b0;

  typedef struct {
    logic            opcode;
    logic            first;
    logic [RB_W-1:0] rb;
    logic [31:0]     word;
  } word_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = 1'b0;
  logic                  in_first_word = 1'b0;
  logic [RB_W-1:0]       in_record_bytes = '0;
  logic [DATA_W-1:0]     in_data_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KIND_W-1:0]     out_kind;
  logic [PAGE_NUM_W-1:0] out_page_number;
  logic [BYTE_OFF_W-1:0] out_byte_offset;
  logic [DATA_W-1:0]     out_write_data;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  paged_record_packer_with_count_header u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_first_word   (in_first_word),
    .in_record_bytes (in_record_bytes),
    .in_data_word    (in_data_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_page_number (out_page_number),
    .out_byte_offset (out_byte_offset),
    .out_write_data  (out_write_data),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  word_item_t word_queue[$];
  word_item_t drv_item;
  result_t    pending_writes[$];

  logic                   quiet = 1'b0;
  logic [PAGES_CFG_W-1:0] pages_cfg = 7'd1;
  logic [PB_W-1:0]        point_cfg = 9'd4;

  logic [PAGE_NUM_W-1:0] pg_now = '0;
  logic [OFFSET_W-1:0]   off_now = 13'd4;
  logic [POINTS_W-1:0]   pts_now = '0;
  logic [USED_W-1:0]     used_now = 19'd4;
  logic [RB_W-1:0]       rec_left = '0;
  logic                  dropping = 1'b0;

  int items_sent = 0;
  int results_seen = 0;
  int page_changes = 0;
  int rejects = 0;
  int settings_run = 0;
  int errors = 0;
  int cycles = 0;

  task automatic post_result(input kind_t k, input logic [PAGE_NUM_W-1:0] pg,
                             input logic [BYTE_OFF_W-1:0] off, input logic [DATA_W-1:0] d,
                             input logic lst);
    result_t r;
    r.kind = k;
    r.page_number = pg;
    r.byte_offset = off;
    r.write_data = d;
    r.last = lst;
    pending_writes.push_back(r);
  endtask

  // page placement model, one call per accepted item
  task automatic place_word(input word_item_t it);
    int pages, cap, pb, rb;
    rb = int'(it.rb);
    if (it.opcode == OPC_CLOSE) begin
      post_result(KIND_HEADER, pg_now, '0, 32'(pts_now), 1'b1);
      return;
    end
    if (it.first) begin
      pages = (pages_cfg > MAXP) ? MAXP : int'(pages_cfg);
      cap = pages * PAGE_B;
      pb = (point_cfg < 4) ? 4 : int'(point_cfg);
      rec_left = '0;
      if (rb == 0 || rb % 4 != 0 || rb > MAXR || used_now >= cap || used_now + rb >= cap) begin
        dropping = 1'b1;
        rejects++;
        post_result(KIND_REJECT, pg_now, '0, '0, 1'b1);
        return;
      end
      if (off_now + rb > PAGE_B) begin
        post_result(KIND_HEADER, pg_now, '0, 32'(pts_now), 1'b0);
        if (pg_now + 1 >= pages) begin
          dropping = 1'b1;
          rejects++;
          post_result(KIND_REJECT, pg_now, '0, '0, 1'b1);
          return;
        end
        pg_now = pg_now + 1'b1;
        off_now = OFFSET_W'(HEADER_BYTES);
        pts_now = '0;
        used_now = USED_W'(PAGE_B * pg_now + off_now);
        page_changes++;
      end
      dropping = 1'b0;
      off_now = OFFSET_W'(off_now + rb);
      used_now = USED_W'(used_now + rb);
      pts_now = POINTS_W'(pts_now + rb / pb);
      rec_left = RB_W'(rb);
    end else if (dropping || rec_left == 0) begin
      return;
    end
    post_result(KIND_DATA, pg_now, BYTE_OFF_W'(off_now - rec_left), it.word, 1'b1);
    rec_left = rec_left - 9'd4;
  endtask

  always @(posedge clk) begin : drive_words
    logic fire;
    fire = in_valid && in_ready;
    if (rst_n) begin
      if (fire) begin
        place_word(drv_item);
        items_sent++;
      end
      if (!in_valid || fire) begin
        if (word_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 27)) begin
          drv_item = word_queue.pop_front();
          in_valid <= 1'b1;
          in_opcode <= drv_item.opcode;
          in_first_word <= drv_item.first;
          in_record_bytes <= drv_item.rb;
          in_data_word <= drv_item.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_writes
    result_t want, got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.kind = kind_t'(out_kind);
        got.page_number = out_page_number;
        got.byte_offset = out_byte_offset;
        got.write_data = out_write_data;
        got.last = out_last;
        results_seen++;
        if (pending_writes.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result kind %0d page %0d off %0d data %h last %0d",
                     $realtime, got.kind, got.page_number, got.byte_offset, got.write_data,
                     got.last);
          errors++;
        end else begin
          want = pending_writes.pop_front();
          if (got.kind !== want.kind || got.page_number !== want.page_number ||
              got.byte_offset !== want.byte_offset || got.write_data !== want.write_data ||
              got.last !== want.last) begin
            if (errors < 10) begin
              $display("%0t: mismatch, expected kind %0d page %0d off %0d data %h last %0d",
                       $realtime, want.kind, want.page_number, want.byte_offset,
                       want.write_data, want.last);
              $display("%0t:                got kind %0d page %0d off %0d data %h last %0d",
                       $realtime, got.kind, got.page_number, got.byte_offset,
                       got.write_data, got.last);
            end
            errors++;
          end
        end
      end
      out_ready <= quiet || $urandom_range(0, 99) >= 27;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_writes.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_item(input logic op, input logic fw, input logic [RB_W-1:0] rb,
                          input logic [31:0] w);
    word_item_t it;
    it.opcode = op;
    it.first = fw;
    it.rb = rb;
    it.word = w;
    word_queue.push_back(it);
  endtask

  task automatic queue_record(input int rb, input int n, inout int made);
    add_item(OPC_PUT, 1'b1, RB_W'(rb), $urandom);
    for (int i = 1; i < n; i++)
      add_item(OPC_PUT, 1'b0, RB_W'($urandom), $urandom);
    made += n;
  endtask

  task automatic random_traffic(input int budget);
    int made, sel, rb, n;
    made = 0;
    while (made < budget) begin
      sel = $urandom_range(0, 99);
      if (sel < 48) begin
        rb = 4 * $urandom_range(1, 8);
        queue_record(rb, rb / 4, made);
      end else if (sel < 52) begin
        rb = 4 * $urandom_range(9, 64);
        queue_record(rb, rb / 4, made);
      end else if (sel < 78) begin
        rb = 4 * $urandom_range(16, 64);
        queue_record(rb, $urandom_range(1, 3), made);
      end else if (sel < 86) begin
        add_item(OPC_CLOSE, 1'($urandom), RB_W'($urandom), $urandom);
        made++;
      end else if (sel < 94) begin
        queue_record($urandom_range(0, 511), $urandom_range(1, 2), made);
      end else begin
        // stray words, ignored by the block unless an earlier record still has words left
        repeat ($urandom_range(1, 2)) add_item(OPC_PUT, 1'b0, RB_W'($urandom), $urandom);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PAGES_IN_USE)
      pages_cfg = val[PAGES_CFG_W-1:0];
    else
      point_cfg = val[PB_W-1:0];
  endtask

  task automatic drain();
    do @(negedge clk); while (word_queue.size() != 0 || in_valid || pending_writes.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] pages, input logic [CFG_DATA_W-1:0] pt,
                           input logic calm, input int budget);
    write_reg(CFG_PAGES_IN_USE, pages);
    write_reg(CFG_POINT_BYTES, pt);
    @(negedge clk);
    quiet = calm;
    settings_run++;
    random_traffic(budget);
    drain();
  endtask

  initial begin : stimulus
    int dummy;
    dummy = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_PAGES_IN_USE, 9'd1);
    write_reg(CFG_POINT_BYTES, 9'd4);
    @(negedge clk);
    settings_run++;

    add_item(OPC_CLOSE, 1'b1, 9'd511, 32'hFFFF_FFFF);
    add_item(OPC_PUT, 1'b0, 9'd0, 32'h0);
    add_item(OPC_PUT, 1'b1, 9'd8, 32'hFFFF_FFFF);
    add_item(OPC_PUT, 1'b0, 9'd511, 32'h0);
    add_item(OPC_PUT, 1'b0, 9'd8, 32'hA5A5_A5A5);
    add_item(OPC_PUT, 1'b1, 9'd0, 32'h1);
    add_item(OPC_PUT, 1'b0, 9'd4, 32'h2);
    add_item(OPC_PUT, 1'b1, 9'd6, 32'h3);
    add_item(OPC_PUT, 1'b1, 9'd260, 32'h4);
    add_item(OPC_PUT, 1'b1, 9'd511, 32'h5);
    add_item(OPC_PUT, 1'b1, 9'd256, 32'h6);
    add_item(OPC_PUT, 1'b0, 9'd0, 32'h7);
    add_item(OPC_PUT, 1'b0, 9'd0, 32'h8);
    // new record before the previous one is complete
    add_item(OPC_PUT, 1'b1, 9'd4, 32'h1234_5678);
    add_item(OPC_CLOSE, 1'b0, 9'd0, 32'h0);
    drain();

    write_reg(CFG_PAGES_IN_USE, 9'd64);
    write_reg(CFG_POINT_BYTES, 9'd4);
    @(negedge clk);
    settings_run++;
    // enough reserved space to force a page change with its header write
    repeat (16) queue_record(256, 1, dummy);
    add_item(OPC_CLOSE, 1'b0, 9'd0, 32'h0);
    random_traffic(150);
    drain();

    run_phase(9'd64, 9'd256, 1'b0, 150);
    run_phase(9'd3, 9'd0, 1'b0, 150);
    run_phase(9'd0, 9'd3, 1'b0, 150);
    run_phase(9'd64, 9'd511, 1'b1, 150);
    run_phase(9'h1FF, 9'd12, 1'b0, 150);
    run_phase(9'd1, 9'd256, 1'b0, 150);
    run_phase(9'd64, 9'd7, 1'b0, 150);
    run_phase(9'd40, 9'd100, 1'b0, 150);

    $display("%0d items over %0d register settings gave %0d results", items_sent, settings_run,
             results_seen);
    $display("%0d page changes, %0d rejected records, %0d mismatches", page_changes, rejects,
             errors);
    if (errors == 0 && pending_writes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
